// ----- hdl/cjht_pkg.sv -----
// ----------------------------------------------------------------------------
// cjht_pkg
// Shared types and constants for the chained join hash table: field widths,
// function and status codes, and the command passed from front to back.
// ----------------------------------------------------------------------------
package cjht_pkg;

    localparam int unsigned MAX_ENTRIES = 1024;
    localparam int ENTRY_BITS  = $clog2(MAX_ENTRIES);
    localparam int CURSOR_BITS = ENTRY_BITS + 1;
    localparam int HASH_BITS   = 64;
    localparam int DATA_BITS   = 64;
    localparam int FUNC_BITS   = 2;
    localparam int STATUS_BITS = 2;

    localparam logic [CURSOR_BITS-1:0] CHAIN_END = CURSOR_BITS'(MAX_ENTRIES);

    // Function codes on the input channel
    localparam logic [FUNC_BITS-1:0] FUNC_INSERT      = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_BUILD       = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_PROBE_START = 2'd2;
    localparam logic [FUNC_BITS-1:0] FUNC_PROBE_NEXT  = 2'd3;

    // Status codes on the output channel
    localparam logic [STATUS_BITS-1:0] ST_OK              = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_TABLE_FULL      = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_INSERT_AFTER    = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_PROBE_BEFORE    = 2'd3;

    // Work kinds resolved by the front
    typedef enum logic [2:0] {
        OP_INSERT,
        OP_REPLY,
        OP_BUILD,
        OP_HEAD,
        OP_ENTRY
    } op_t;

    // Command queued between front and back
    typedef struct packed {
        op_t                     op;
        logic [STATUS_BITS-1:0]  status;
        logic [ENTRY_BITS-1:0]   addr;     // entry index, bucket or mask
        logic [CURSOR_BITS-1:0]  link;     // parked hash bits on insert
        logic [CURSOR_BITS-1:0]  count;    // entry count after this transaction
        logic [DATA_BITS-1:0]    payload;
    } cmd_t;

endpackage

// ----- hdl/cjht_ifs.sv -----
// ----------------------------------------------------------------------------
// cjht_ifs
// Valid/ready channel interfaces for request and response transactions.
// ----------------------------------------------------------------------------
interface cjht_in_if;
    logic                                valid;
    logic                                ready;
    logic [cjht_pkg::FUNC_BITS-1:0]      func;
    logic [cjht_pkg::HASH_BITS-1:0]      key_hash;
    logic [cjht_pkg::DATA_BITS-1:0]      payload;
    logic [cjht_pkg::CURSOR_BITS-1:0]    cursor;

    modport source (output valid, func, key_hash, payload, cursor, input ready);
    modport sink   (input valid, func, key_hash, payload, cursor, output ready);
endinterface

interface cjht_out_if;
    logic                                valid;
    logic                                ready;
    logic [cjht_pkg::STATUS_BITS-1:0]    status;
    logic                                found;
    logic [cjht_pkg::ENTRY_BITS-1:0]     entry_index;
    logic [cjht_pkg::DATA_BITS-1:0]      entry_data;
    logic [cjht_pkg::CURSOR_BITS-1:0]    next_cursor;
    logic [cjht_pkg::CURSOR_BITS-1:0]    entry_count;

    modport source (output valid, status, found, entry_index, entry_data,
                    next_cursor, entry_count, input ready);
    modport sink   (input valid, status, found, entry_index, entry_data,
                    next_cursor, entry_count, output ready);
endinterface

// ----- hdl/chained_join_hash_table.sv -----
// ----------------------------------------------------------------------------
// chained_join_hash_table
// Build-then-probe chained hash table for the build side of a hash join.
// ----------------------------------------------------------------------------
// The front accepts one request transaction per cycle while its command queue
// has room, and the table produces exactly one response transaction per
// request, in order. In the back end an insert or a rejected request is
// answered straight from the queue, a probe next reads the entry memories and
// a probe start reads the bucket head and then, for a nonempty bucket, the
// entry memories; all of these reads are registered. A build clears all 1024
// bucket heads one per cycle, then links each stored entry by an entry read,
// a bucket read and a write back, and then loads its response; requests
// behind it wait in the queue. Hash values are not compared on probe: a chain
// returns every entry of the bucket, newest first.
module chained_join_hash_table
#(
    parameter int PAYLOAD_BITS = 64,
    parameter int QUEUE_DEPTH  = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    cjht_in_if.sink       in_ch,
    cjht_out_if.source    out_ch
);

    logic           q_push, q_pop, q_full, q_empty;
    cjht_pkg::cmd_t push_cmd, pop_cmd;

    // Classify requests
    cjht_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .q_full (q_full),
        .q_push (q_push),
        .q_cmd  (push_cmd)
    );

    // Decouple front and back
    cjht_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    // Execute against memories
    cjht_back
    #(
        .PAYLOAD_BITS (PAYLOAD_BITS)
    )
    u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_cmd   (pop_cmd),
        .q_pop   (q_pop),
        .out_ch  (out_ch)
    );

    // A returned entry is always ok and lies below the entry count
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.found |->
            out_ch.status == cjht_pkg::ST_OK &&
            {1'b0, out_ch.entry_index} < out_ch.entry_count)
        else $error("returned entry outside the stored range");

    // A response without an entry carries end of chain and no data
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.found |->
            out_ch.next_cursor == cjht_pkg::CHAIN_END && out_ch.entry_data == '0)
        else $error("empty response carries a cursor or data");

    // The queue is never pushed while full nor popped while empty
    assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full) && !(q_pop && q_empty))
        else $error("command queue overrun or underrun");

    // A returned successor is end of chain or a stored entry below the entry count
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.found |->
            out_ch.next_cursor == cjht_pkg::CHAIN_END ||
            out_ch.next_cursor < out_ch.entry_count)
        else $error("chain successor outside the stored range");

endmodule

// ----- hdl/cjht_front.sv -----
// ----------------------------------------------------------------------------
// cjht_front
// Accepts request transactions, tracks entry count, build flag and bucket
// mask, and resolves each request into a command for the back end.
// ----------------------------------------------------------------------------
module cjht_front
(
    input  logic              clk,
    input  logic              rst_n,
    cjht_in_if.sink           in_ch,
    input  logic              q_full,
    output logic              q_push,
    output cjht_pkg::cmd_t    q_cmd
);

    localparam int EB = cjht_pkg::ENTRY_BITS;
    localparam int CB = cjht_pkg::CURSOR_BITS;

    logic [CB-1:0] count_reg, count_next;
    logic          built_reg, built_next;
    logic [EB-1:0] mask_reg, mask_next;

    // Mask of the smallest power of two that holds n entries (0 for n <= 1)
    function automatic logic [EB-1:0] size_mask(input logic [CB-1:0] n);
        logic [CB-1:0] m;
        logic [EB-1:0] s;
        begin
            m = (n == '0) ? '0 : n - CB'(1);
            s = m[EB-1:0];
            for (int k = 1; k < EB; k = k * 2)
            begin
                s = s | (s >> k);
            end
            return s;
        end
    endfunction

    assign in_ch.ready = !q_full;
    assign q_push      = in_ch.valid && !q_full;

    // Classify the request against current table state
    always_comb
    begin
        count_next    = count_reg;
        built_next    = built_reg;
        mask_next     = mask_reg;
        q_cmd.op      = cjht_pkg::OP_REPLY;
        q_cmd.status  = cjht_pkg::ST_OK;
        q_cmd.addr    = '0;
        q_cmd.link    = in_ch.key_hash[CB-1:0];
        q_cmd.count   = count_reg;
        q_cmd.payload = in_ch.payload;
        case (in_ch.func)
            cjht_pkg::FUNC_INSERT:
            begin
                if (built_reg)
                begin
                    q_cmd.status = cjht_pkg::ST_INSERT_AFTER;
                end
                else if (count_reg >= CB'(cjht_pkg::MAX_ENTRIES))
                begin
                    q_cmd.status = cjht_pkg::ST_TABLE_FULL;
                end
                else
                begin
                    q_cmd.op    = cjht_pkg::OP_INSERT;
                    q_cmd.addr  = count_reg[EB-1:0];
                    q_cmd.count = count_reg + CB'(1);
                    count_next  = count_reg + CB'(1);
                end
            end
            cjht_pkg::FUNC_BUILD:
            begin
                if (!built_reg)
                begin
                    q_cmd.op   = cjht_pkg::OP_BUILD;
                    q_cmd.addr = size_mask(count_reg);
                    mask_next  = size_mask(count_reg);
                    built_next = 1'b1;
                end
            end
            cjht_pkg::FUNC_PROBE_START:
            begin
                if (!built_reg)
                begin
                    q_cmd.status = cjht_pkg::ST_PROBE_BEFORE;
                end
                else
                begin
                    q_cmd.op   = cjht_pkg::OP_HEAD;
                    q_cmd.addr = in_ch.key_hash[EB-1:0] & mask_reg;
                end
            end
            default:
            begin
                if (!built_reg)
                begin
                    q_cmd.status = cjht_pkg::ST_PROBE_BEFORE;
                end
                else if (in_ch.cursor < count_reg)
                begin
                    q_cmd.op   = cjht_pkg::OP_ENTRY;
                    q_cmd.addr = in_ch.cursor[EB-1:0];
                end
            end
        endcase
    end

    // Hold table state; advance only on an accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            built_reg <= 1'b0;
            mask_reg  <= '0;
        end
        else if (q_push)
        begin
            count_reg <= count_next;
            built_reg <= built_next;
            mask_reg  <= mask_next;
        end
    end

endmodule

// ----- hdl/cjht_queue.sv -----
// ----------------------------------------------------------------------------
// cjht_queue
// Small first-in first-out queue of commands between front and back.
// ----------------------------------------------------------------------------
module cjht_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  cjht_pkg::cmd_t    push_cmd,
    output logic              full,
    input  logic              pop,
    output cjht_pkg::cmd_t    pop_cmd,
    output logic              empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cjht_pkg::cmd_t slot_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  cnt_reg;

    assign full    = cnt_reg == CW'(DEPTH);
    assign empty   = cnt_reg == '0;
    assign pop_cmd = slot_reg[rd_ptr_reg];

    // Store a pushed command
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

endmodule

// ----- hdl/cjht_back.sv -----
// ----------------------------------------------------------------------------
// cjht_back
// Executes queued commands against the entry and bucket memories: stores
// entries, runs the build sweep and walk, follows probes, and holds the
// response register.
// ----------------------------------------------------------------------------
module cjht_back
#(
    parameter int PAYLOAD_BITS = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  cjht_pkg::cmd_t    q_cmd,
    output logic              q_pop,
    cjht_out_if.source        out_ch
);

    localparam int EB = cjht_pkg::ENTRY_BITS;
    localparam int CB = cjht_pkg::CURSOR_BITS;
    localparam int DB = cjht_pkg::DATA_BITS;
    localparam int NE = cjht_pkg::MAX_ENTRIES;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_ENTRY,
        S_CLEAR,
        S_WALK_RD,
        S_WALK_HD,
        S_WALK_WR,
        S_DONE
    } state_t;

    // Memories and their registered read data
    logic [PAYLOAD_BITS-1:0] pl_mem [NE];
    logic [CB-1:0]           lk_mem [NE];
    logic [CB-1:0]           hd_mem [NE];
    logic [PAYLOAD_BITS-1:0] pl_rd_reg;
    logic [CB-1:0]           lk_rd_reg;
    logic [CB-1:0]           hd_rd_reg;

    logic                    pl_we, lk_we, hd_we, ent_re, hd_re;
    logic [EB-1:0]           pl_waddr, lk_waddr, hd_waddr, ent_raddr, hd_raddr;
    logic [PAYLOAD_BITS-1:0] pl_wdata;
    logic [CB-1:0]           lk_wdata, hd_wdata;

    // Sequencer state
    state_t        state_reg, state_next;
    logic [EB-1:0] ctr_reg, ctr_next;
    logic [EB-1:0] mask_reg, mask_next;
    logic [EB-1:0] pos_reg, pos_next;
    logic [EB-1:0] idx_reg, idx_next;
    logic [CB-1:0] count_reg, count_next;

    // Response register
    logic                               res_valid_reg, res_valid_next;
    logic [cjht_pkg::STATUS_BITS-1:0]   res_status_reg, res_status_next;
    logic                               res_found_reg, res_found_next;
    logic [EB-1:0]                      res_index_reg, res_index_next;
    logic [DB-1:0]                      res_data_reg, res_data_next;
    logic [CB-1:0]                      res_next_reg, res_next_next;
    logic [CB-1:0]                      res_count_reg, res_count_next;

    logic          res_free;
    logic          res_load;
    logic [EB-1:0] walk_pos;

    assign res_free = !res_valid_reg || out_ch.ready;
    assign walk_pos = lk_rd_reg[EB-1:0] & mask_reg;

    assign out_ch.valid       = res_valid_reg;
    assign out_ch.status      = res_status_reg;
    assign out_ch.found       = res_found_reg;
    assign out_ch.entry_index = res_index_reg;
    assign out_ch.entry_data  = res_data_reg;
    assign out_ch.next_cursor = res_next_reg;
    assign out_ch.entry_count = res_count_reg;

    // Sequence commands, memory ports and response loads
    always_comb
    begin
        state_next      = state_reg;
        ctr_next        = ctr_reg;
        mask_next       = mask_reg;
        pos_next        = pos_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        q_pop           = 1'b0;
        pl_we           = 1'b0;
        lk_we           = 1'b0;
        hd_we           = 1'b0;
        ent_re          = 1'b0;
        hd_re           = 1'b0;
        pl_waddr        = q_cmd.addr;
        pl_wdata        = q_cmd.payload[PAYLOAD_BITS-1:0];
        lk_waddr        = q_cmd.addr;
        lk_wdata        = q_cmd.link;
        hd_waddr        = ctr_reg;
        hd_wdata        = cjht_pkg::CHAIN_END;
        ent_raddr       = q_cmd.addr;
        hd_raddr        = q_cmd.addr;
        res_load        = 1'b0;
        res_status_next = cjht_pkg::ST_OK;
        res_found_next  = 1'b0;
        res_index_next  = '0;
        res_data_next   = '0;
        res_next_next   = cjht_pkg::CHAIN_END;
        res_count_next  = count_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    case (q_cmd.op)
                        cjht_pkg::OP_INSERT:
                        begin
                            if (res_free)
                            begin
                                pl_we          = 1'b1;
                                lk_we          = 1'b1;
                                q_pop          = 1'b1;
                                res_load       = 1'b1;
                                res_index_next = q_cmd.addr;
                                res_count_next = q_cmd.count;
                            end
                        end
                        cjht_pkg::OP_REPLY:
                        begin
                            if (res_free)
                            begin
                                q_pop           = 1'b1;
                                res_load        = 1'b1;
                                res_status_next = q_cmd.status;
                                res_count_next  = q_cmd.count;
                            end
                        end
                        cjht_pkg::OP_HEAD:
                        begin
                            hd_re      = 1'b1;
                            q_pop      = 1'b1;
                            count_next = q_cmd.count;
                            state_next = S_HEAD;
                        end
                        cjht_pkg::OP_ENTRY:
                        begin
                            ent_re     = 1'b1;
                            q_pop      = 1'b1;
                            idx_next   = q_cmd.addr;
                            count_next = q_cmd.count;
                            state_next = S_ENTRY;
                        end
                        cjht_pkg::OP_BUILD:
                        begin
                            q_pop      = 1'b1;
                            mask_next  = q_cmd.addr;
                            count_next = q_cmd.count;
                            ctr_next   = '0;
                            state_next = S_CLEAR;
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_HEAD:
            begin
                if (hd_rd_reg == cjht_pkg::CHAIN_END)
                begin
                    if (res_free)
                    begin
                        res_load   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    ent_re     = 1'b1;
                    ent_raddr  = hd_rd_reg[EB-1:0];
                    idx_next   = hd_rd_reg[EB-1:0];
                    state_next = S_ENTRY;
                end
            end
            S_ENTRY:
            begin
                if (res_free)
                begin
                    res_load       = 1'b1;
                    res_found_next = 1'b1;
                    res_index_next = idx_reg;
                    res_data_next  = DB'(pl_rd_reg);
                    res_next_next  = lk_rd_reg;
                    state_next     = S_IDLE;
                end
            end
            S_CLEAR:
            begin
                hd_we    = 1'b1;
                ctr_next = ctr_reg + EB'(1);
                if (ctr_reg == EB'(NE - 1))
                begin
                    ctr_next   = '0;
                    state_next = (count_reg == '0) ? S_DONE : S_WALK_RD;
                end
            end
            S_WALK_RD:
            begin
                ent_re     = 1'b1;
                ent_raddr  = ctr_reg;
                state_next = S_WALK_HD;
            end
            S_WALK_HD:
            begin
                hd_re      = 1'b1;
                hd_raddr   = walk_pos;
                pos_next   = walk_pos;
                state_next = S_WALK_WR;
            end
            S_WALK_WR:
            begin
                // Prepend entry to its bucket chain
                hd_we    = 1'b1;
                hd_waddr = pos_reg;
                hd_wdata = CB'(ctr_reg);
                lk_we    = 1'b1;
                lk_waddr = ctr_reg;
                lk_wdata = hd_rd_reg;
                if (CB'(ctr_reg) + CB'(1) == count_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ctr_next   = ctr_reg + EB'(1);
                    state_next = S_WALK_RD;
                end
            end
            S_DONE:
            begin
                if (res_free)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else
        begin
            res_valid_next = res_valid_reg && !out_ch.ready;
        end
    end

    // Hold state and the response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ctr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ctr_reg       <= ctr_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg  <= mask_next;
        pos_reg   <= pos_next;
        idx_reg   <= idx_next;
        count_reg <= count_next;
        if (res_load)
        begin
            res_status_reg <= res_status_next;
            res_found_reg  <= res_found_next;
            res_index_reg  <= res_index_next;
            res_data_reg   <= res_data_next;
            res_next_reg   <= res_next_next;
            res_count_reg  <= res_count_next;
        end
    end

    // Entry memories: one write and one registered read port each
    always_ff @(posedge clk)
    begin
        if (pl_we)
        begin
            pl_mem[pl_waddr] <= pl_wdata;
        end
        if (ent_re)
        begin
            pl_rd_reg <= pl_mem[ent_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (lk_we)
        begin
            lk_mem[lk_waddr] <= lk_wdata;
        end
        if (ent_re)
        begin
            lk_rd_reg <= lk_mem[ent_raddr];
        end
    end

    // Bucket head memory
    always_ff @(posedge clk)
    begin
        if (hd_we)
        begin
            hd_mem[hd_waddr] <= hd_wdata;
        end
        if (hd_re)
        begin
            hd_rd_reg <= hd_mem[hd_raddr];
        end
    end

endmodule
